@@ hdl/lz4_block_decompressor_unit_defines.svh @@
// Assertion helpers shared by the decompressor RTL.
`ifndef LZ4_BLOCK_DECOMPRESSOR_UNIT_DEFINES_SVH
`define LZ4_BLOCK_DECOMPRESSOR_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define LZ4BD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lz4bd check failed");

// Next-cycle implication, checked out of reset.
`define LZ4BD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lz4bd check failed");

`endif

@@ hdl/lz4bd_pkg.sv @@
package lz4bd_pkg;

    localparam int HISTORY_DEPTH = 65536;
    localparam int ADDR_W        = $clog2(HISTORY_DEPTH);
    localparam int LENGTH_BITS   = 32;
    localparam int HDR_LEN       = 8 + 4;
    localparam int MAGIC_LEN     = 7;

    typedef enum logic [9:0] {
        PH_START   = 10'b00_0000_0001,
        PH_HDR     = 10'b00_0000_0010,
        PH_TOKEN   = 10'b00_0000_0100,
        PH_LITEXT  = 10'b00_0000_1000,
        PH_LIT     = 10'b00_0001_0000,
        PH_OFFLO   = 10'b00_0010_0000,
        PH_OFFHI   = 10'b00_0100_0000,
        PH_MATEXT  = 10'b00_1000_0000,
        PH_COPY    = 10'b01_0000_0000,
        PH_DISCARD = 10'b10_0000_0000
    } t_phase;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_HDR   = 3'd1,
        ST_TRUNC     = 3'd2,
        ST_BAD_OFF   = 3'd3,
        ST_SIZE_MISM = 3'd4,
        ST_BUSY      = 3'd5
    } t_status;

    // One request in flight between acceptance and the output register.
    typedef struct packed {
        logic              emit;
        logic              src_ram;
        logic              fwd;
        logic [7:0]        byte_val;
        logic [ADDR_W-1:0] waddr;
        logic              pend;
        logic              done;
        t_status           status;
    } t_stage;

    // Magic "mozLz40".
    function automatic logic [7:0] magic_byte(input logic [2:0] idx);
        logic [7:0] v;
        unique case (idx)
            3'd0:    v = 8'h6D;
            3'd1:    v = 8'h6F;
            3'd2:    v = 8'h7A;
            3'd3:    v = 8'h4C;
            3'd4:    v = 8'h7A;
            3'd5:    v = 8'h34;
            3'd6:    v = 8'h30;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

endpackage

@@ hdl/lz4_block_decompressor_unit.sv @@
// LZ4 block decompressor with a 64 KiB history memory.
// Input stream: one request per compressed byte or copy tick. tuser[0] = 1 marks a
// tick, tdata[7:0] carries the compressed byte, tlast marks the final byte of a frame.
// Output stream: exactly one result per input request. tdata holds the byte and the
// status, tuser holds out_valid and copy_pending, tlast flags the end of a frame.
// While copy_pending is set the producer sends ticks; each tick yields one match byte.
// header_enable is written through i_cfg_wr_en / i_cfg_wr_data; write it only
// while the block is idle, which the block itself does not enforce.
// A request enters the pending stage, which resolves its history read, then the
// output register. Throughput: one request per cycle unless m_axis stalls, set by
// the single read and single write port of the history RAM; a match at offset one
// is forwarded from the byte being written, so back-to-back ticks never wait.
// Reset: frame state clears, header_enable returns to 1; the history is not cleared.
// Output stall: the output register holds its result and the pending stage holds
// one more; tready drops only when both are full.
`include "lz4_block_decompressor_unit_defines.svh"

module lz4_block_decompressor_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_wr_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
    input  logic        s_axis_tlast,  // last_byte
    input  logic        s_axis_tuser,  // [0] action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,  // [7:0] out_byte, [10:8] status, rest zero
    output logic        m_axis_tlast,  // frame_done
    output logic [1:0]  m_axis_tuser   // [0] out_valid, [1] copy_pending
);

    localparam int AW = lz4bd_pkg::ADDR_W;
    localparam int LB = lz4bd_pkg::LENGTH_BITS;

    logic                  r_hdr_en;
    lz4bd_pkg::t_phase     r_phase, n_phase;
    logic [3:0]            r_hc, n_hc;
    logic [31:0]           r_exp, n_exp;
    logic [31:0]           r_prod, n_prod;
    logic [LB-1:0]         r_run, n_run;
    logic [3:0]            r_nib, n_nib;
    logic [15:0]           r_off, n_off;
    logic [AW-1:0]         r_wp, n_wp;
    logic                  r_end, n_end;

    logic                  r_p_valid;
    lz4bd_pkg::t_stage     r_p, n_p;
    logic                  r_o_valid;
    lz4bd_pkg::t_stage     r_o, n_o;

    logic                  accept, advance;
    logic [7:0]            ram_rdata, p_byte;
    logic [AW-1:0]         raddr;
    logic [7:0]            b;
    logic                  last;
    logic [LB:0]           sum, sum4;

    lz4bd_pkg::t_phase     eff;
    logic                  emit, emit_ram, fin, fail;
    lz4bd_pkg::t_status    fail_code, st;

    assign b       = s_axis_tdata;
    assign last    = s_axis_tlast;
    assign advance = r_p_valid && (!r_o_valid || m_axis_tready);
    assign s_axis_tready = !r_p_valid || advance;
    assign accept  = s_axis_tvalid && s_axis_tready;
    assign raddr   = r_wp - AW'(r_off);
    assign p_byte  = (r_p.src_ram && !r_p.fwd) ? ram_rdata : r_p.byte_val;
    assign sum     = {1'b0, r_run} + (LB + 1)'(b);
    assign sum4    = sum + (LB + 1)'(4);

    lz4bd_ram #(.WIDTH(8), .DEPTH(lz4bd_pkg::HISTORY_DEPTH)) u_hist (
        .i_clk   (i_clk),
        .i_we    (advance && r_p.emit),
        .i_waddr (r_p.waddr),
        .i_wdata (p_byte),
        .i_re    (accept),
        .i_raddr (raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_phase = r_phase; n_hc = r_hc; n_exp = r_exp; n_prod = r_prod;
        n_run = r_run; n_nib = r_nib; n_off = r_off; n_wp = r_wp; n_end = r_end;
        emit = 1'b0; emit_ram = 1'b0; fin = 1'b0; fail = 1'b0;
        fail_code = lz4bd_pkg::ST_OK;
        st = lz4bd_pkg::ST_OK;
        eff = r_phase;

        if (s_axis_tuser) begin
            if (r_phase == lz4bd_pkg::PH_COPY && r_run != '0) begin
                emit = 1'b1; emit_ram = 1'b1;
                n_run = r_run - LB'(1);
                if (n_run == '0) begin
                    if (r_end) fin = 1'b1;
                    else n_phase = lz4bd_pkg::PH_TOKEN;
                end
            end
        end else if (r_phase == lz4bd_pkg::PH_DISCARD) begin
            if (last) n_phase = lz4bd_pkg::PH_START;
        end else if (r_phase == lz4bd_pkg::PH_COPY) begin
            fail = 1'b1; fail_code = lz4bd_pkg::ST_BUSY;
        end else begin
            if (r_phase == lz4bd_pkg::PH_START) begin
                eff = r_hdr_en ? lz4bd_pkg::PH_HDR : lz4bd_pkg::PH_TOKEN;
            end
            n_phase = eff;
            unique case (eff)
                lz4bd_pkg::PH_HDR: begin
                    if (r_hc < 4'(lz4bd_pkg::MAGIC_LEN) && b != lz4bd_pkg::magic_byte(r_hc[2:0]))
                    begin
                        fail = 1'b1; fail_code = lz4bd_pkg::ST_BAD_HDR;
                    end else begin
                        if (r_hc >= 4'd8) begin
                            n_exp = r_exp | ({24'b0, b} << {r_hc[1:0], 3'b000});
                        end
                        n_hc = r_hc + 4'd1;
                        if (n_hc >= 4'(lz4bd_pkg::HDR_LEN)) begin
                            n_phase = lz4bd_pkg::PH_TOKEN;
                            if (last) fin = 1'b1;
                        end else if (last) begin
                            fail = 1'b1; fail_code = lz4bd_pkg::ST_BAD_HDR;
                        end
                    end
                end
                lz4bd_pkg::PH_TOKEN: begin
                    n_nib = b[3:0];
                    if (b[7:4] == 4'hF) begin
                        n_run = LB'(15); n_phase = lz4bd_pkg::PH_LITEXT;
                        if (last) begin fail = 1'b1; fail_code = lz4bd_pkg::ST_TRUNC; end
                    end else if (b[7:4] != 4'h0) begin
                        n_run = LB'(b[7:4]); n_phase = lz4bd_pkg::PH_LIT;
                        if (last) begin fail = 1'b1; fail_code = lz4bd_pkg::ST_TRUNC; end
                    end else if (last) begin
                        fin = 1'b1;
                    end else begin
                        n_phase = lz4bd_pkg::PH_OFFLO;
                    end
                end
                lz4bd_pkg::PH_LITEXT: begin
                    if (sum[LB]) begin
                        fail = 1'b1; fail_code = lz4bd_pkg::ST_TRUNC;
                    end else begin
                        n_run = sum[LB-1:0];
                        if (b != 8'hFF) n_phase = lz4bd_pkg::PH_LIT;
                        if (last) begin fail = 1'b1; fail_code = lz4bd_pkg::ST_TRUNC; end
                    end
                end
                lz4bd_pkg::PH_LIT: begin
                    emit = 1'b1;
                    if (r_run != '0) n_run = r_run - LB'(1);
                    if (n_run == '0) begin
                        if (last) fin = 1'b1;
                        else n_phase = lz4bd_pkg::PH_OFFLO;
                    end else if (last) begin
                        fail = 1'b1; fail_code = lz4bd_pkg::ST_TRUNC;
                    end
                end
                lz4bd_pkg::PH_OFFLO: begin
                    n_off = {8'h00, b};
                    if (last) begin fail = 1'b1; fail_code = lz4bd_pkg::ST_TRUNC; end
                    else n_phase = lz4bd_pkg::PH_OFFHI;
                end
                lz4bd_pkg::PH_OFFHI: begin
                    n_off = {b, r_off[7:0]};
                    if (n_off == 16'h0000 || {16'h0000, n_off} > r_prod) begin
                        fail = 1'b1; fail_code = lz4bd_pkg::ST_BAD_OFF;
                    end else if (r_nib == 4'hF) begin
                        n_run = LB'(15); n_phase = lz4bd_pkg::PH_MATEXT;
                        if (last) begin fail = 1'b1; fail_code = lz4bd_pkg::ST_TRUNC; end
                    end else begin
                        n_run = LB'(r_nib) + LB'(4);
                        n_phase = lz4bd_pkg::PH_COPY; n_end = last;
                    end
                end
                lz4bd_pkg::PH_MATEXT: begin
                    if (b == 8'hFF) begin
                        if (sum[LB]) begin
                            fail = 1'b1; fail_code = lz4bd_pkg::ST_TRUNC;
                        end else begin
                            n_run = sum[LB-1:0];
                            if (last) begin fail = 1'b1; fail_code = lz4bd_pkg::ST_TRUNC; end
                        end
                    end else if (sum4[LB]) begin
                        fail = 1'b1; fail_code = lz4bd_pkg::ST_TRUNC;
                    end else begin
                        n_run = sum4[LB-1:0];
                        n_phase = lz4bd_pkg::PH_COPY; n_end = last;
                    end
                end
                default: n_phase = lz4bd_pkg::PH_START;
            endcase
        end

        if (emit) begin
            n_wp = r_wp + AW'(1);
            if (r_prod != 32'hFFFF_FFFF) n_prod = r_prod + 32'd1;
        end

        if (fin) begin
            st = (n_exp != 32'd0 && n_prod != n_exp) ? lz4bd_pkg::ST_SIZE_MISM
                                                     : lz4bd_pkg::ST_OK;
        end else if (fail) begin
            st = fail_code;
        end

        // frame restart on finish or failure; a failure before last drops the rest
        if (fin || fail) begin
            n_phase = (fail && !last) ? lz4bd_pkg::PH_DISCARD : lz4bd_pkg::PH_START;
            n_hc = '0; n_exp = '0; n_prod = '0; n_run = '0;
            n_nib = '0; n_off = '0; n_end = 1'b0;
        end

        n_p.emit     = emit;
        n_p.src_ram  = emit_ram;
        n_p.fwd      = emit_ram && advance && r_p.emit && (raddr == r_p.waddr);
        n_p.byte_val = emit_ram ? p_byte : (emit ? b : 8'h00);
        n_p.waddr    = r_wp;
        n_p.pend     = (n_phase == lz4bd_pkg::PH_COPY) && (n_run != '0);
        n_p.done     = fin || fail;
        n_p.status   = st;
    end

    // pending stage with the resolved byte, ready for the output register
    always_comb begin
        n_o          = r_p;
        n_o.byte_val = p_byte;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_en  <= 1'b1;
            r_phase   <= lz4bd_pkg::PH_START;
            r_hc      <= '0;
            r_exp     <= '0;
            r_prod    <= '0;
            r_run     <= '0;
            r_nib     <= '0;
            r_off     <= '0;
            r_wp      <= '0;
            r_end     <= 1'b0;
            r_p_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) r_hdr_en <= i_cfg_wr_data;
            if (accept) begin
                r_phase <= n_phase; r_hc <= n_hc; r_exp <= n_exp; r_prod <= n_prod;
                r_run <= n_run; r_nib <= n_nib; r_off <= n_off; r_wp <= n_wp;
                r_end <= n_end;
            end
            if (accept) r_p_valid <= 1'b1;
            else if (advance) r_p_valid <= 1'b0;
            if (advance) r_o_valid <= 1'b1;
            else if (m_axis_tready) r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) r_p <= n_p;
        if (advance) r_o <= n_o;
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = {5'b00000, r_o.status, r_o.byte_val};
    assign m_axis_tlast  = r_o.done;
    assign m_axis_tuser  = {r_o.pend, r_o.emit};

    `LZ4BD_ASSERT_NEXT(a_out_hold, r_o_valid && !m_axis_tready, r_o_valid)
    `LZ4BD_ASSERT_NOW(a_status_on_done, r_o_valid && !r_o.done, r_o.status == lz4bd_pkg::ST_OK)
    `LZ4BD_ASSERT_NOW(a_fwd_only_copy, r_p_valid && r_p.fwd, r_p.src_ram && r_p.emit)
    `LZ4BD_ASSERT_NOW(a_stall_full, !s_axis_tready, r_p_valid && r_o_valid)

endmodule

@@ hdl/lz4bd_ram.sv @@
module lz4bd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;

    localparam int          WATCHDOG_LIMIT = 5000;
    localparam logic [63:0] LEN_MAX        = 64'hFFFF_FFFF;

    typedef struct packed {
        logic       vld;
        logic [7:0] data;
        logic       pend;
        logic       done;
        logic [2:0] st;
    } t_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic        i_cfg_wr_data = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;
    logic        s_axis_tlast = 1'b0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic [1:0]  m_axis_tuser;

    lz4_block_decompressor_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #6 i_clk = ~i_clk;

    // decoder mirror
    logic [7:0]  magic_ref [7] = '{8'h6D, 8'h6F, 8'h7A, 8'h4C, 8'h7A, 8'h34, 8'h30};
    logic        hdr_en;
    lz4bd_pkg::t_phase ph;
    int unsigned hdr_cnt;
    logic [31:0] size_want;
    logic [31:0] produced;
    logic [63:0] run_len;
    logic [3:0]  mlen_nib;
    logic [15:0] moffset;
    logic [7:0]  window [65536];
    logic [15:0] wr_ptr;
    logic        end_flag;
    t_result     res;

    t_result     pending_q [$];
    logic [7:0]  frame_q [$];
    int          errors = 0;
    int          items = 0;
    int          frames_done = 0;
    int          copies = 0;
    bit          quiet = 1'b0;
    int          idle_cycles = 0;

    function automatic void restart_frame();
        ph = lz4bd_pkg::PH_START;
        hdr_cnt = 0;
        size_want = '0;
        produced = '0;
        run_len = '0;
        mlen_nib = '0;
        moffset = '0;
        end_flag = 1'b0;
    endfunction

    function automatic void put_out(logic [7:0] v);
        window[wr_ptr] = v;
        wr_ptr = wr_ptr + 16'd1;
        if (produced != 32'hFFFF_FFFF) produced = produced + 32'd1;
        res.vld = 1'b1;
        res.data = v;
    endfunction

    function automatic void close_ok();
        res.done = 1'b1;
        res.st = (size_want != 0 && produced != size_want) ? lz4bd_pkg::ST_SIZE_MISM
                                                           : lz4bd_pkg::ST_OK;
        restart_frame();
    endfunction

    function automatic void abort(lz4bd_pkg::t_status code, logic lst);
        res.done = 1'b1;
        res.st = code;
        restart_frame();
        if (!lst) ph = lz4bd_pkg::PH_DISCARD;
    endfunction

    function automatic t_result decode_step(logic act, logic [7:0] b, logic lst);
        logic [63:0] sum;
        res = '0;
        if (act) begin
            if (ph == lz4bd_pkg::PH_COPY && run_len > 0) begin
                put_out(window[wr_ptr - moffset]);
                run_len = run_len - 1;
                if (run_len == 0) begin
                    if (end_flag) close_ok();
                    else ph = lz4bd_pkg::PH_TOKEN;
                end
            end
        end else if (ph == lz4bd_pkg::PH_DISCARD) begin
            if (lst) restart_frame();
        end else if (ph == lz4bd_pkg::PH_COPY) begin
            abort(lz4bd_pkg::ST_BUSY, lst);
        end else begin
            if (ph == lz4bd_pkg::PH_START)
                ph = hdr_en ? lz4bd_pkg::PH_HDR : lz4bd_pkg::PH_TOKEN;
            case (ph)
                lz4bd_pkg::PH_HDR: begin
                    if (hdr_cnt < 7 && b != magic_ref[hdr_cnt]) begin
                        abort(lz4bd_pkg::ST_BAD_HDR, lst);
                    end else begin
                        if (hdr_cnt >= 8 && hdr_cnt < 12)
                            size_want = size_want | (32'(b) << (8 * (hdr_cnt - 8)));
                        hdr_cnt++;
                        if (hdr_cnt >= 12) begin
                            ph = lz4bd_pkg::PH_TOKEN;
                            if (lst) close_ok();
                        end else if (lst) begin
                            abort(lz4bd_pkg::ST_BAD_HDR, lst);
                        end
                    end
                end
                lz4bd_pkg::PH_TOKEN: begin
                    mlen_nib = b[3:0];
                    if (b[7:4] == 4'hF) begin
                        run_len = 15;
                        ph = lz4bd_pkg::PH_LITEXT;
                        if (lst) abort(lz4bd_pkg::ST_TRUNC, lst);
                    end else if (b[7:4] != 0) begin
                        run_len = b[7:4];
                        ph = lz4bd_pkg::PH_LIT;
                        if (lst) abort(lz4bd_pkg::ST_TRUNC, lst);
                    end else if (lst) begin
                        close_ok();
                    end else begin
                        ph = lz4bd_pkg::PH_OFFLO;
                    end
                end
                lz4bd_pkg::PH_LITEXT: begin
                    sum = run_len + b;
                    if (sum > LEN_MAX) begin
                        abort(lz4bd_pkg::ST_TRUNC, lst);
                    end else begin
                        run_len = sum;
                        if (b != 8'hFF) ph = lz4bd_pkg::PH_LIT;
                        if (lst) abort(lz4bd_pkg::ST_TRUNC, lst);
                    end
                end
                lz4bd_pkg::PH_LIT: begin
                    put_out(b);
                    if (run_len > 0) run_len = run_len - 1;
                    if (run_len == 0) begin
                        if (lst) close_ok();
                        else ph = lz4bd_pkg::PH_OFFLO;
                    end else if (lst) begin
                        abort(lz4bd_pkg::ST_TRUNC, lst);
                    end
                end
                lz4bd_pkg::PH_OFFLO: begin
                    moffset = {8'h00, b};
                    if (lst) abort(lz4bd_pkg::ST_TRUNC, lst);
                    else ph = lz4bd_pkg::PH_OFFHI;
                end
                lz4bd_pkg::PH_OFFHI: begin
                    moffset = {b, moffset[7:0]};
                    if (moffset == 0 || 32'(moffset) > produced) begin
                        abort(lz4bd_pkg::ST_BAD_OFF, lst);
                    end else if (mlen_nib == 4'hF) begin
                        run_len = 15;
                        ph = lz4bd_pkg::PH_MATEXT;
                        if (lst) abort(lz4bd_pkg::ST_TRUNC, lst);
                    end else begin
                        run_len = 64'(mlen_nib) + 4;
                        ph = lz4bd_pkg::PH_COPY;
                        end_flag = lst;
                    end
                end
                lz4bd_pkg::PH_MATEXT: begin
                    sum = run_len + b;
                    if (b == 8'hFF) begin
                        if (sum > LEN_MAX) begin
                            abort(lz4bd_pkg::ST_TRUNC, lst);
                        end else begin
                            run_len = sum;
                            if (lst) abort(lz4bd_pkg::ST_TRUNC, lst);
                        end
                    end else begin
                        sum = sum + 4;
                        if (sum > LEN_MAX) begin
                            abort(lz4bd_pkg::ST_TRUNC, lst);
                        end else begin
                            run_len = sum;
                            ph = lz4bd_pkg::PH_COPY;
                            end_flag = lst;
                        end
                    end
                end
                default: restart_frame();
            endcase
        end
        res.pend = (ph == lz4bd_pkg::PH_COPY && run_len > 0);
        return res;
    endfunction

    function automatic bit copy_due();
        return ph == lz4bd_pkg::PH_COPY && run_len > 0;
    endfunction

    function automatic void add_byte(logic [7:0] v);
        frame_q.insert(frame_q.size(), v);
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        errors++;
        $display("mismatch %s: got %0h, want %0h", what, got, want);
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_q.size() == 0) begin
                report_mismatch("unexpected result", m_axis_tdata, 0);
            end else begin
                want = pending_q.pop_front();
                if (m_axis_tuser[0] !== want.vld)
                    report_mismatch("out_valid", m_axis_tuser[0], want.vld);
                if (m_axis_tdata[7:0] !== want.data)
                    report_mismatch("out_byte", m_axis_tdata[7:0], want.data);
                if (m_axis_tdata[10:8] !== want.st)
                    report_mismatch("status", m_axis_tdata[10:8], want.st);
                if (m_axis_tdata[15:11] !== 5'd0)
                    report_mismatch("tdata pad", m_axis_tdata[15:11], 0);
                if (m_axis_tuser[1] !== want.pend)
                    report_mismatch("copy_pending", m_axis_tuser[1], want.pend);
                if (m_axis_tlast !== want.done)
                    report_mismatch("frame_done", m_axis_tlast, want.done);
                if (want.done) frames_done++;
                if (want.vld) copies++;
            end
        end
    end

    always @(negedge i_clk) begin
        m_axis_tready <= quiet ? 1'b1 : ($urandom_range(99) >= 20);
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no request moved in %0d cycles", WATCHDOG_LIMIT);
            $display("tb_top: FAIL");
            $finish;
        end
    end

    task automatic send_item(logic act, logic [7:0] b, logic lst);
        @(negedge i_clk);
        while (!quiet && $urandom_range(99) < 20) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser = act;
        s_axis_tdata = b;
        s_axis_tlast = lst;
        do @(posedge i_clk); while (!s_axis_tready);
        pending_q.insert(pending_q.size(), decode_step(act, b, lst));
        items++;
    endtask

    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_header_enable(logic v);
        drain();
        @(negedge i_clk);
        i_cfg_wr_en = 1'b1;
        i_cfg_wr_data = v;
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
        hdr_en = v;
    endtask

    // sends frame_q, answering pending copies with ticks; noise adds stray bytes and ticks
    task automatic play_frame(bit noise);
        for (int i = 0; i < frame_q.size(); i++) begin
            send_item(1'b0, frame_q[i], i == frame_q.size() - 1);
            while (copy_due()) begin
                if (noise && $urandom_range(199) == 0)
                    send_item(1'b0, 8'($urandom), 1'($urandom));
                else
                    send_item(1'b1, 8'($urandom), 1'($urandom));
            end
            if (noise && $urandom_range(49) == 0)
                send_item(1'b1, 8'($urandom), 1'($urandom));
        end
    endtask

    task automatic push_header(logic [31:0] sz);
        for (int i = 0; i < 7; i++) add_byte(magic_ref[i]);
        add_byte(8'($urandom));
        for (int i = 0; i < 4; i++) add_byte(sz[8*i +: 8]);
    endtask

    task automatic push_ext(int rem);
        while (rem >= 255) begin
            add_byte(8'hFF);
            rem -= 255;
        end
        add_byte(8'(rem));
    endtask

    // builds a well-formed frame and returns its decoded size
    task automatic build_block(int nseq, bit end_match, output int total);
        int lit;
        int mlen;
        int off;
        bit with_match;
        total = 0;
        for (int s = 0; s < nseq; s++) begin
            with_match = (s < nseq - 1) || end_match;
            lit = ($urandom_range(9) == 0) ? $urandom_range(300, 15) : $urandom_range(6);
            if (total == 0 && with_match && lit == 0) lit = 1;
            mlen = ($urandom_range(9) == 0) ? $urandom_range(290, 19) : $urandom_range(12, 4);
            add_byte({4'(lit < 15 ? lit : 15),
                      4'(with_match ? (mlen - 4 < 15 ? mlen - 4 : 15) : $urandom)});
            if (lit >= 15) push_ext(lit - 15);
            for (int i = 0; i < lit; i++) add_byte(8'($urandom));
            total += lit;
            if (with_match) begin
                off = $urandom_range(total < 65535 ? total : 65535, 1);
                add_byte(off[7:0]);
                add_byte(off[15:8]);
                if (mlen - 4 >= 15) push_ext(mlen - 19);
                total += mlen;
            end
        end
    endtask

    task automatic test_header_faults();
        write_header_enable(1'b1);
        frame_q = '{8'h6D, 8'h6F, 8'h7B, 8'h11, 8'h22};
        play_frame(0);
        frame_q = '{8'h6D, 8'h6F, 8'h7A};
        play_frame(0);
        // empty block: last lands on the final size byte
        frame_q.delete();
        push_header(32'h0000_0000);
        play_frame(0);
        frame_q.delete();
        push_header(32'hFFFF_FFFF);
        play_frame(0);
    endtask

    task automatic test_raw_literals();
        write_header_enable(1'b0);
        frame_q = '{8'h20, 8'h00, 8'hFF, 8'h00};
        play_frame(0);
        frame_q = '{8'h00};
        play_frame(0);
    endtask

    task automatic test_match_paths();
        // overlap copy at offset one, then a final match marked last
        frame_q = '{8'h10, 8'hA5, 8'h01, 8'h00, 8'h0F, 8'h01, 8'h00, 8'h00};
        play_frame(0);
        frame_q = '{8'h20, 8'h5A, 8'hC3, 8'h02, 8'h00};
        play_frame(0);
        frame_q = '{8'h10, 8'h77, 8'h00, 8'h00, 8'h12};
        play_frame(0);
        frame_q = '{8'h10, 8'h77, 8'h05, 8'h00, 8'h12};
        play_frame(0);
    endtask

    task automatic test_truncation_and_busy();
        frame_q = '{8'h20, 8'h01};
        play_frame(0);
        frame_q = '{8'h10, 8'h01, 8'h01};
        play_frame(0);
        // stray tick with no copy owed, then a frame with a match, then a literal run cut short by last
        send_item(1'b1, 8'hFF, 1'b1);
        frame_q = '{8'h10, 8'h42, 8'h01, 8'h00};
        play_frame(0);
        send_item(1'b0, 8'hFF, 1'b0);
        send_item(1'b0, 8'h00, 1'b0);
        send_item(1'b0, 8'h13, 1'b1);
    endtask

    task automatic test_random_frames();
        int total;
        int mode;
        bit sent_pause = 1'b0;
        while (items < 950) begin
            quiet = (items > 400 && items < 550);
            if ($urandom_range(4) == 0) write_header_enable(1'($urandom));
            if (!sent_pause && items > 650) begin
                drain();
                sent_pause = 1'b1;
            end
            frame_q.delete();
            build_block($urandom_range(4, 1), $urandom_range(3) == 0, total);
            if (hdr_en) begin
                mode = $urandom_range(2);
                frame_q = {frame_q, frame_q};
                frame_q = frame_q[0 : frame_q.size() / 2 - 1];
                for (int i = 0; i < 12; i++) frame_q.push_front(8'h00);
                for (int i = 0; i < 7; i++) frame_q[i] = magic_ref[i];
                frame_q[7] = 8'($urandom);
                total = (mode == 0) ? 0 : (mode == 1) ? total : total + 1;
                for (int i = 0; i < 4; i++) frame_q[8 + i] = 8'(total >> (8 * i));
            end
            if ($urandom_range(9) == 0)
                frame_q[$urandom_range(frame_q.size() - 1)] ^= 8'($urandom_range(255, 1));
            play_frame(1);
        end
        quiet = 1'b0;
    endtask

    initial begin
        restart_frame();
        hdr_en = 1'b1;
        wr_ptr = '0;
        foreach (window[i]) window[i] = 8'h00;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_header_faults();
        test_raw_literals();
        test_match_paths();
        test_truncation_and_busy();
        test_random_frames();

        drain();
        repeat (10) @(posedge i_clk);
        $display("covered %0d requests, %0d frame ends, %0d output bytes", items,
                 frames_done, copies);
        $display("headers on and off, matches, truncation, bad offsets, busy, stalls");
        if (errors == 0 && pending_q.size() == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("errors %0d, results outstanding %0d", errors, pending_q.size());
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule
